// ===== rtl/pfd_pkg.sv =====
package pfd_pkg;

    localparam int unsigned CapWidth   = 32;
    localparam int unsigned FieldWidth = 29;
    localparam int unsigned AccWidth   = 64;
    localparam int unsigned ShiftWidth = 7;

    // Shift position past which varint bits are dropped
    localparam logic [ShiftWidth-1:0] ShiftLimit = 7'd64;
    localparam logic [ShiftWidth-1:0] ShiftStep  = 7'd7;

    localparam logic [CapWidth-1:0] CapReset = '1;

    typedef enum logic [1:0] {
        PH_TAG     = 2'd0,
        PH_VALUE   = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_UINT32 = 2'd0,
        KIND_UINT64 = 2'd1,
        KIND_BYTES  = 2'd2,
        KIND_STRING = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_DONE     = 3'd1,
        ST_BYTE     = 3'd2,
        ST_TAG_ERR  = 3'd3,
        ST_TOO_LONG = 3'd4,
        ST_RANGE    = 3'd5,
        ST_CAPACITY = 3'd6
    } status_t;

    localparam logic [2:0] WireVarint = 3'd0;
    localparam logic [2:0] WireLen    = 3'd2;

    typedef struct packed {
        phase_t                  phase;
        logic [AccWidth-1:0]     acc;
        logic [ShiftWidth-1:0]   shift;
        logic [CapWidth-1:0]     position;
        logic [CapWidth-1:0]     remaining;
        logic [FieldWidth-1:0]   held_field;
        kind_t                   held_kind;
        logic [CapWidth-1:0]     held_max;
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [AccWidth-1:0] value;
        logic [7:0]          payload_byte;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [7:0]            in_byte;
        logic [FieldWidth-1:0] expected_field;
        kind_t                 field_kind;
        logic [CapWidth-1:0]   max_length;
    } item_t;

endpackage

// ===== rtl/pfd_step.sv =====
module pfd_step (
    input  pfd_pkg::state_t             cur,
    input  pfd_pkg::item_t              item,
    input  logic [pfd_pkg::CapWidth-1:0] capacity,
    output pfd_pkg::state_t             nxt,
    output pfd_pkg::result_t            res
);

    logic                              sample;
    logic                              final_byte;
    logic [pfd_pkg::AccWidth-1:0]      acc_new;
    logic [pfd_pkg::ShiftWidth-1:0]    shift_new;
    logic [2:0]                        wire_exp;
    logic                              tag_ok;
    logic                              too_long;
    logic [pfd_pkg::CapWidth-1:0]      rem_dec;
    logic [pfd_pkg::AccWidth-1:0]      max_ext;

    always_comb
    begin
        nxt        = cur;
        res        = '0;
        res.status = pfd_pkg::ST_BUSY;

        sample     = (cur.phase == pfd_pkg::PH_TAG) && (cur.shift == '0);
        final_byte = ~item.in_byte[7];

        if (cur.shift < pfd_pkg::ShiftLimit)
        begin
            acc_new   = cur.acc | ({57'd0, item.in_byte[6:0]} << cur.shift[5:0]);
            shift_new = cur.shift + pfd_pkg::ShiftStep;
        end
        else
        begin
            acc_new   = cur.acc;
            shift_new = cur.shift;
        end

        rem_dec = (cur.remaining != '0) ? cur.remaining - 32'd1 : '0;

        if (cur.position >= capacity)
        begin
            // byte not consumed, position holds
            nxt.phase     = pfd_pkg::PH_TAG;
            nxt.acc       = '0;
            nxt.shift     = '0;
            nxt.remaining = '0;
            res.status    = pfd_pkg::ST_CAPACITY;
            res.last      = 1'b1;
        end
        else
        begin
            nxt.position = cur.position + 32'd1;
            if (sample)
            begin
                nxt.held_field = item.expected_field;
                nxt.held_kind  = item.field_kind;
                nxt.held_max   = item.max_length;
            end
        end

        wire_exp = nxt.held_kind[1] ? pfd_pkg::WireLen : pfd_pkg::WireVarint;
        tag_ok   = (acc_new[2:0] == wire_exp) &&
                   (acc_new[63:3] == {32'd0, nxt.held_field});
        max_ext  = {32'd0, nxt.held_max};
        too_long = (nxt.held_kind == pfd_pkg::KIND_STRING) ? (acc_new >= max_ext)
                                                          : (acc_new > max_ext);

        if (cur.position < capacity)
        begin
            unique case (cur.phase)
                pfd_pkg::PH_TAG:
                begin
                    if (!final_byte)
                    begin
                        nxt.acc   = acc_new;
                        nxt.shift = shift_new;
                    end
                    else
                    begin
                        nxt.acc   = '0;
                        nxt.shift = '0;
                        if (!tag_ok)
                        begin
                            nxt.remaining = '0;
                            res.status    = pfd_pkg::ST_TAG_ERR;
                            res.last      = 1'b1;
                        end
                        else
                        begin
                            nxt.phase = nxt.held_kind[1] ? pfd_pkg::PH_LENGTH
                                                         : pfd_pkg::PH_VALUE;
                        end
                    end
                end
                pfd_pkg::PH_VALUE:
                begin
                    if (!final_byte)
                    begin
                        nxt.acc   = acc_new;
                        nxt.shift = shift_new;
                    end
                    else
                    begin
                        nxt.phase     = pfd_pkg::PH_TAG;
                        nxt.acc       = '0;
                        nxt.shift     = '0;
                        nxt.remaining = '0;
                        res.last      = 1'b1;
                        if (cur.held_kind == pfd_pkg::KIND_UINT32 && acc_new[63:32] != '0)
                        begin
                            res.status = pfd_pkg::ST_RANGE;
                        end
                        else
                        begin
                            res.status = pfd_pkg::ST_DONE;
                            res.value  = acc_new;
                        end
                    end
                end
                pfd_pkg::PH_LENGTH:
                begin
                    if (!final_byte)
                    begin
                        nxt.acc   = acc_new;
                        nxt.shift = shift_new;
                    end
                    else
                    begin
                        nxt.phase     = pfd_pkg::PH_TAG;
                        nxt.acc       = '0;
                        nxt.shift     = '0;
                        nxt.remaining = '0;
                        priority if (too_long)
                        begin
                            res.status = pfd_pkg::ST_TOO_LONG;
                            res.last   = 1'b1;
                        end
                        else if (acc_new == '0)
                        begin
                            res.status = pfd_pkg::ST_DONE;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            // length fits in 32 bits once past the room check
                            nxt.remaining = acc_new[31:0];
                            nxt.phase     = pfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                pfd_pkg::PH_PAYLOAD:
                begin
                    res.status       = pfd_pkg::ST_BYTE;
                    res.payload_byte = item.in_byte;
                    nxt.remaining    = rem_dec;
                    if (rem_dec == '0)
                    begin
                        nxt.phase = pfd_pkg::PH_TAG;
                        nxt.acc   = '0;
                        nxt.shift = '0;
                        res.last  = 1'b1;
                    end
                end
                default:
                begin
                    nxt.phase = pfd_pkg::PH_TAG;
                end
            endcase
        end
    end

endmodule

// ===== rtl/protobuf_field_decoder.sv =====
// Protobuf field decoder: takes one encoded message byte per word and returns
// exactly one result word per byte in the cycle after it is accepted, at one
// byte per cycle unless stalled; the whole tag/varint/length step for a byte
// is done in one pass into the output register, which a downstream stall only
// holds (s_tready drops while a result waits and m_tready is low). The field
// number, kind and room in s_tdata/s_tuser are sampled on a field's first byte
// only. buffer_capacity may be written only while no result is pending.
module protobuf_field_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,      // buffer_capacity

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,       // in_byte[7:0], expected_field[36:8],
                                       // max_length[68:37], zero pad
    input  logic [1:0]  s_tuser,       // field_kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // value[63:0], payload_byte[71:64]
    output logic [2:0]  m_tuser,       // status
    output logic        m_tlast
);

    pfd_pkg::state_t               state_reg;
    pfd_pkg::state_t               state_next;
    pfd_pkg::result_t              res_reg;
    pfd_pkg::result_t              res_next;
    pfd_pkg::item_t                item;
    logic [pfd_pkg::CapWidth-1:0]  cap_reg;
    logic                          valid_reg;
    logic                          accept;

    assign item.in_byte        = s_tdata[7:0];
    assign item.expected_field = s_tdata[36:8];
    assign item.max_length     = s_tdata[68:37];
    assign item.field_kind     = pfd_pkg::kind_t'(s_tuser);

    assign s_tready  = ~valid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    pfd_step u_step (
        .cur      (state_reg),
        .item     (item),
        .capacity (cap_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // all-zero state is phase PH_TAG with empty accumulators
            state_reg       <= '0;
            cap_reg         <= pfd_pkg::CapReset;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.payload_byte, res_reg.value};
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;

endmodule

// ===== bench/protobuf_field_decoder_tb.sv =====
module protobuf_field_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // in_byte, expected_field, max_length, zero pad
    logic [1:0]  s_tuser;   // field_kind
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // value, payload_byte
    logic [2:0]  m_tuser;   // status
    logic        m_tlast;

    // decoder image kept alongside the block
    logic [31:0]      cap_limit;
    pfd_pkg::phase_t  dec_phase;
    logic [63:0]      dec_acc;
    logic [6:0]       dec_shift;
    logic [31:0]      dec_pos;
    logic [31:0]      dec_left;
    logic [28:0]      hold_field;
    pfd_pkg::kind_t   hold_kind;
    logic [31:0]      hold_room;

    pfd_pkg::result_t pending_q[$];
    logic [7:0]       field_bytes[$];
    int unsigned bytes_sent = 0;
    int unsigned fail_count = 0;
    int unsigned tx_gap_max = 14;
    int unsigned rx_gap_max = 14;
    int unsigned rx_hold = 0;

    protobuf_field_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("protobuf_field_decoder_tb: done, errors");
        $finish;
    end

    function automatic void restart_field();
        dec_phase = pfd_pkg::PH_TAG;
        dec_acc   = '0;
        dec_shift = '0;
        dec_left  = '0;
    endfunction

    // returns 1 on the closing byte of a varint
    function automatic bit take_group(logic [7:0] b);
        if (dec_shift < pfd_pkg::ShiftLimit)
        begin
            dec_acc   = dec_acc | (64'(b[6:0]) << dec_shift);
            dec_shift = dec_shift + pfd_pkg::ShiftStep;
        end
        return !b[7];
    endfunction

    function automatic pfd_pkg::result_t decode_byte(pfd_pkg::item_t it);
        pfd_pkg::result_t r;
        logic [63:0]      acc_val;
        logic [2:0]       wire_exp;
        bit               too_long;
        r = '0;
        r.status = pfd_pkg::ST_BUSY;
        if (dec_pos >= cap_limit)
        begin
            restart_field();
            r.status = pfd_pkg::ST_CAPACITY;
            r.last   = 1'b1;
            return r;
        end
        dec_pos = dec_pos + 32'd1;
        if (dec_phase == pfd_pkg::PH_TAG && dec_shift == '0)
        begin
            hold_field = it.expected_field;
            hold_kind  = it.field_kind;
            hold_room  = it.max_length;
        end
        case (dec_phase)
            pfd_pkg::PH_TAG:
            begin
                if (take_group(it.in_byte))
                begin
                    wire_exp = (hold_kind >= pfd_pkg::KIND_BYTES) ? pfd_pkg::WireLen
                                                                  : pfd_pkg::WireVarint;
                    if (dec_acc[2:0] == wire_exp && (dec_acc >> 3) == 64'(hold_field))
                    begin
                        dec_acc   = '0;
                        dec_shift = '0;
                        dec_phase = (wire_exp == pfd_pkg::WireLen) ? pfd_pkg::PH_LENGTH
                                                                   : pfd_pkg::PH_VALUE;
                    end
                    else
                    begin
                        restart_field();
                        r.status = pfd_pkg::ST_TAG_ERR;
                        r.last   = 1'b1;
                    end
                end
            end
            pfd_pkg::PH_VALUE:
            begin
                if (take_group(it.in_byte))
                begin
                    acc_val = dec_acc;
                    restart_field();
                    r.last = 1'b1;
                    if (hold_kind == pfd_pkg::KIND_UINT32 && acc_val[63:32] != '0)
                        r.status = pfd_pkg::ST_RANGE;
                    else
                    begin
                        r.status = pfd_pkg::ST_DONE;
                        r.value  = acc_val;
                    end
                end
            end
            pfd_pkg::PH_LENGTH:
            begin
                if (take_group(it.in_byte))
                begin
                    acc_val = dec_acc;
                    restart_field();
                    // a string needs one spare byte of room
                    if (hold_kind == pfd_pkg::KIND_STRING)
                        too_long = acc_val >= 64'(hold_room);
                    else
                        too_long = acc_val > 64'(hold_room);
                    if (too_long)
                    begin
                        r.status = pfd_pkg::ST_TOO_LONG;
                        r.last   = 1'b1;
                    end
                    else if (acc_val == '0)
                    begin
                        r.status = pfd_pkg::ST_DONE;
                        r.last   = 1'b1;
                    end
                    else
                    begin
                        dec_left  = acc_val[31:0];
                        dec_phase = pfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            default:
            begin
                if (dec_left != '0)
                    dec_left = dec_left - 32'd1;
                r.status       = pfd_pkg::ST_BYTE;
                r.payload_byte = it.in_byte;
                if (dec_left == '0)
                begin
                    restart_field();
                    r.last = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        pfd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got status %0d value %0h",
                         $time, m_tuser, m_tdata[63:0]);
                fail_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                compare_field("status", want.status, m_tuser);
                compare_field("value", want.value, m_tdata[63:0]);
                compare_field("payload_byte", want.payload_byte, m_tdata[71:64]);
                compare_field("last", want.last, m_tlast);
            end
        end
    end

    // result sink: random stall per word, plus a long hold-off on request
    initial
    begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
                stall = $urandom_range(0, rx_gap_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_byte(pfd_pkg::item_t it);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.max_length, it.expected_field, it.in_byte};
        s_tuser  <= it.field_kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_q.push_back(decode_byte(it));
        bytes_sent++;
    endtask

    // only the first byte's field info should matter; later bytes carry junk
    task automatic send_field(logic [28:0] fnum, pfd_pkg::kind_t kind, logic [31:0] room);
        pfd_pkg::item_t it;
        foreach (field_bytes[i])
        begin
            if (i == 0)
            begin
                it.expected_field = fnum;
                it.field_kind     = kind;
                it.max_length     = room;
            end
            else
            begin
                it.expected_field = 29'($urandom);
                it.field_kind     = pfd_pkg::kind_t'($urandom_range(0, 3));
                it.max_length     = $urandom;
            end
            it.in_byte = field_bytes[i];
            send_byte(it);
        end
        field_bytes.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [31:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cap_limit = cap;
    endtask

    // pad adds redundant zero groups, i.e. a non-minimal encoding
    function automatic void put_varint(logic [63:0] v, int unsigned pad);
        logic [7:0] b;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != '0 || pad > 0)
                b[7] = 1'b1;
            field_bytes.push_back(b);
        end
        while (v != '0);
        while (pad > 0)
        begin
            pad--;
            field_bytes.push_back((pad > 0) ? 8'h80 : 8'h00);
        end
    endfunction

    function automatic logic [63:0] tag_of(logic [28:0] fnum, logic [2:0] wire_type);
        return {32'b0, fnum, wire_type};
    endfunction

    task automatic test_varint_fields();
        // wrong wire type for a varint kind
        put_varint(tag_of(29'd1, pfd_pkg::WireLen), 0);
        send_field(29'd1, pfd_pkg::KIND_UINT32, '0);
        // one past the uint32 range
        put_varint(tag_of(29'd1, pfd_pkg::WireVarint), 0);
        put_varint(64'h1_0000_0000, 0);
        send_field(29'd1, pfd_pkg::KIND_UINT32, '0);
        // overlong uint64: high bits of the tenth group and the whole eleventh dropped
        put_varint(tag_of(29'd1, pfd_pkg::WireVarint), 0);
        repeat (10) field_bytes.push_back(8'hFF);
        field_bytes.push_back(8'h7F);
        send_field(29'd1, pfd_pkg::KIND_UINT64, '1);
    endtask

    task automatic test_length_fields();
        // empty payload with no room at all
        put_varint(tag_of(29'd1, pfd_pkg::WireLen), 0);
        put_varint(64'd0, 0);
        send_field(29'd1, pfd_pkg::KIND_BYTES, '0);
        // string of one byte in one byte of room
        put_varint(tag_of(29'd2, pfd_pkg::WireLen), 0);
        put_varint(64'd1, 0);
        send_field(29'd2, pfd_pkg::KIND_STRING, 32'd1);
        // same length fits as bytes
        put_varint(tag_of(29'd2, pfd_pkg::WireLen), 0);
        put_varint(64'd1, 0);
        field_bytes.push_back(8'hFF);
        send_field(29'd2, pfd_pkg::KIND_BYTES, 32'd1);
    endtask

    task automatic test_capacity();
        drain();
        write_capacity(dec_pos + 32'd5);
        put_varint(tag_of(29'd3, pfd_pkg::WireLen), 0);
        put_varint(64'd10, 0);
        repeat (10) field_bytes.push_back(8'($urandom));
        send_field(29'd3, pfd_pkg::KIND_BYTES, 32'd20);
        drain();
        write_capacity('0);
        repeat (3) field_bytes.push_back(8'($urandom));
        send_field('0, pfd_pkg::KIND_UINT32, '0);
        drain();
        write_capacity(pfd_pkg::CapReset);
        put_varint(tag_of(29'd1, pfd_pkg::WireVarint), 0);
        put_varint(64'd150, 0);
        send_field(29'd1, pfd_pkg::KIND_UINT64, '0);
    endtask

    task automatic random_field();
        pfd_pkg::kind_t kind;
        logic [28:0]    fnum;
        logic [28:0]    tag_fnum;
        logic [2:0]     wire_type;
        logic [63:0]    v;
        logic [31:0]    room;
        int unsigned    shape;
        kind = pfd_pkg::kind_t'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       fnum = '0;
            1:       fnum = 29'd1;
            2:       fnum = '1;
            3:       fnum = 29'($urandom_range(1, 15));
            default: fnum = 29'($urandom);
        endcase
        tag_fnum  = fnum;
        wire_type = (kind >= pfd_pkg::KIND_BYTES) ? pfd_pkg::WireLen : pfd_pkg::WireVarint;
        room      = $urandom;
        shape     = $urandom_range(0, 19);
        if (shape == 0)
            wire_type = 3'($urandom);
        if (shape == 1)
            tag_fnum = fnum ^ (29'd1 << $urandom_range(0, 28));
        put_varint(tag_of(tag_fnum, wire_type), ($urandom_range(0, 9) == 0) ? 1 : 0);
        if (shape == 2)
        begin
            repeat ($urandom_range(1, 5)) field_bytes.push_back(8'($urandom));
        end
        else if (kind < pfd_pkg::KIND_BYTES)
        begin
            case ($urandom_range(0, 6))
                0:       v = '0;
                1:       v = 64'hFFFF_FFFF;
                2:       v = 64'($urandom);
                3:       v = {$urandom, $urandom};
                4:       v = 64'($urandom_range(0, 127));
                5:       v = '1;
                default: v = 64'h1_0000_0000 + 64'($urandom_range(0, 3));
            endcase
            put_varint(v, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        end
        else
        begin
            case ($urandom_range(0, 9))
                7, 8:    v = 64'($urandom_range(7, 40));
                9:       v = 64'h1_0000_0000 + 64'($urandom);
                default: v = 64'($urandom_range(0, 6));
            endcase
            case ($urandom_range(0, 6))
                0:       room = v[31:0];
                1:       room = v[31:0] + 32'd1;
                2:       room = v[31:0] + 32'($urandom_range(2, 100));
                3:       room = v[31:0] - 32'd1;
                4:       room = '0;
                5:       room = '1;
                default: room = $urandom;
            endcase
            put_varint(v, ($urandom_range(0, 7) == 0) ? 1 : 0);
            if (!(v > 64'(room) || (kind == pfd_pkg::KIND_STRING && v >= 64'(room))))
                repeat (v) field_bytes.push_back(8'($urandom));
        end
        send_field(fnum, kind, room);
    endtask

    // sink stops for a long stretch while the source keeps pushing back to back
    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_hold    = 80;
        repeat (4) random_field();
        tx_gap_max = 14;
    endtask

    task automatic test_random_stream();
        int unsigned target;
        for (int chunk = 0; chunk < 5; chunk++)
        begin
            drain();
            case (chunk)
                0:
                begin
                    write_capacity(pfd_pkg::CapReset);
                    tx_gap_max = 14;
                    rx_gap_max = 14;
                end
                1:
                begin
                    write_capacity(32'($urandom_range(32'h0010_0000, 32'hFFFF_FFFE)));
                    tx_gap_max = 0;
                    rx_gap_max = 14;
                end
                2:
                begin
                    // runs out of room near the end of the chunk
                    write_capacity(dec_pos + 32'd150);
                    tx_gap_max = 14;
                    rx_gap_max = 0;
                end
                3:
                begin
                    write_capacity(pfd_pkg::CapReset);
                    tx_gap_max = 0;
                    rx_gap_max = 0;
                end
                default:
                begin
                    tx_gap_max = 14;
                    rx_gap_max = 14;
                end
            endcase
            target = bytes_sent + 190;
            while (bytes_sent < target) random_field();
        end
    endtask

    initial
    begin : run
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cap_limit  = pfd_pkg::CapReset;
        dec_pos    = '0;
        hold_field = '0;
        hold_kind  = pfd_pkg::KIND_UINT32;
        hold_room  = '0;
        restart_field();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_varint_fields();
        test_length_fields();
        test_capacity();
        test_backpressure();
        test_random_stream();
        drain();
        if (fail_count == 0)
            $display("protobuf_field_decoder_tb: done, clean");
        else
            $display("protobuf_field_decoder_tb: done, errors");
        $finish;
    end

endmodule
